// ===== hw/rtl/sorted_insert_priority_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted-insert priority queue.
// Shorthand for clocked assertions used by the checker module.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Assertion sampled on clk_i and ignored while rst_ni is low.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion sampled on clk_i that also holds during reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-insert priority queue package
// Shared types, codes and widths for the queue cells and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned PriceW = 32;
  localparam int unsigned FillW  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } spq_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
  } spq_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue cell
// Holds one entry, compares it with the key being inserted and takes its
// new contents from itself, its left neighbor, its right neighbor or the
// request.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                     clk_i,
  input  spq_ctrl_t                ctrl_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic signed [KeyW-1:0]   new_key_i,
  input  logic [PriceW-1:0]        new_price_i,
  input  logic                     prev_flag_i,
  input  logic signed [KeyW-1:0]   prev_key_i,
  input  logic [PriceW-1:0]        prev_price_i,
  input  logic signed [KeyW-1:0]   next_key_i,
  input  logic [PriceW-1:0]        next_price_i,
  output logic signed [KeyW-1:0]   key_o,
  output logic [PriceW-1:0]        price_o,
  output logic                     flag_o
);

  logic signed [KeyW-1:0] key_q, key_d;
  logic [PriceW-1:0]      price_q, price_d;
  logic                   occupied;

  assign occupied = (count_i > CNT_W'(IDX));
  // The new entry lands at or left of this cell when the cell is free or
  // its key is not smaller than the new key.
  assign flag_o   = !occupied || !(key_q < new_key_i);

  always_comb begin
    key_d   = key_q;
    price_d = price_q;
    if (ctrl_i.ins && flag_o) begin
      if (prev_flag_i) begin
        key_d   = prev_key_i;
        price_d = prev_price_i;
      end else begin
        key_d   = new_key_i;
        price_d = new_price_i;
      end
    end else if (ctrl_i.pop) begin
      key_d   = next_key_i;
      price_d = next_price_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    price_q <= price_d;
  end

  assign key_o   = key_q;
  assign price_o = price_q;

endmodule

// ===== hw/rtl/sorted_insert_priority_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-insert priority queue core
// Keeps up to DEPTH key/price entries in ascending key order in a row of
// cells and answers insert and pop requests.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one request (op, key, price) when in_valid_i and
//   in_ready_o are both high. An insert places the entry ahead of all stored
//   entries with a key not smaller; a pop returns the smallest entry.
//   Every request gives exactly one result on the output channel, taken when
//   out_valid_o and out_ready_i are both high. A full insert or an empty pop
//   leaves the store unchanged and reports it in status_o.
//   The result shows in the cycle after acceptance.
//   Throughput is one request per cycle while the receiver takes results; every
//   cell compares and shifts in parallel, so the store update finishes in the accepting cycle.
//   The output register frees in the same cycle it is taken, so a request
//   is accepted while the previous result is being taken.
//   When the receiver stalls, the result holds and in_ready_o drops until it
//   is taken. Reset empties the store and clears the output valid.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic signed [KeyW-1:0]  key_i,
  input  logic [PriceW-1:0]       price_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [KeyW-1:0]  out_key_o,
  output logic [PriceW-1:0]       out_price_o,
  output logic [1:0]              status_o,
  output logic [FillW-1:0]        fill_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]        count_q, count_d;
  logic                   accept, full, empty;
  spq_ctrl_t              ctrl;
  spq_status_e            status;

  logic signed [KeyW-1:0] cell_key  [DEPTH];
  logic [PriceW-1:0]      cell_price[DEPTH];
  logic                   cell_flag [DEPTH];

  logic                   out_valid_q;
  logic signed [KeyW-1:0] out_key_q;
  logic [PriceW-1:0]      out_price_q;
  spq_status_e            status_q;
  logic [FillW-1:0]       fill_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.ins = accept && (op_i == OP_INSERT) && !full;
  assign ctrl.pop = accept && (op_i == OP_POP) && !empty;

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    status = ST_DONE;
    if (op_i == OP_INSERT && full) begin
      status = ST_FULL;
    end else if (op_i == OP_POP && empty) begin
      status = ST_EMPTY;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   prev_flag;
    logic signed [KeyW-1:0] prev_key, next_key;
    logic [PriceW-1:0]      prev_price, next_price;

    if (i == 0) begin : g_head
      assign prev_flag  = 1'b0;
      assign prev_key   = '0;
      assign prev_price = '0;
    end else begin : g_body
      assign prev_flag  = cell_flag[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_price = cell_price[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key   = cell_key[i];
      assign next_price = cell_price[i];
    end else begin : g_inner
      assign next_key   = cell_key[i+1];
      assign next_price = cell_price[i+1];
    end

    spq_cell #(
      .IDX  (i),
      .CNT_W(CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .new_key_i   (key_i),
      .new_price_i (price_i),
      .prev_flag_i (prev_flag),
      .prev_key_i  (prev_key),
      .prev_price_i(prev_price),
      .next_key_i  (next_key),
      .next_price_i(next_price),
      .key_o       (cell_key[i]),
      .price_o     (cell_price[i]),
      .flag_o      (cell_flag[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_key_q   <= ctrl.pop ? cell_key[0] : '0;
      out_price_q <= ctrl.pop ? cell_price[0] : '0;
      status_q    <= status;
      fill_q      <= FillW'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_price_o = out_price_q;
  assign status_o    = status_q;
  assign fill_o      = fill_q;

endmodule

// ===== hw/rtl/spq_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue port checker
// Watches the top-level ports of the queue core for results that break the
// expected ordering and flow rules.
// ----------------------------------------------------------------------------
`include "sorted_insert_priority_queue_core_assert.svh"

module spq_chk import spq_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic signed [KeyW-1:0] out_key_o,
  input logic [PriceW-1:0]      out_price_o,
  input logic [1:0]             status_o,
  input logic [FillW-1:0]       fill_o
);

  // A stalled result holds its value until it is taken.
  `SPQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_key_o) && $stable(out_price_o) && $stable(status_o) && $stable(fill_o), "stalled result changed")

  // With no result pending the core must take a new request.
  `SPQ_ASSERT(a_ready_when_idle, !out_valid_o |-> in_ready_o, "core not ready while output is empty")

  // A rejected request returns no entry.
  `SPQ_ASSERT(a_fail_zero, out_valid_o && status_o != ST_DONE |-> out_key_o == '0 && out_price_o == '0, "failed request returned data")

  // Each request moves the fill level by at most one entry.
  `SPQ_ASSERT(a_fill_step, out_valid_o && out_ready_i ##1 out_valid_o |-> fill_o == $past(fill_o) || fill_o == $past(fill_o) + 5'd1 || fill_o == $past(fill_o) - 5'd1, "fill level jumped")

  // No result is offered straight out of reset.
  `SPQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result offered after reset")

endmodule

bind sorted_insert_priority_queue_core spq_chk u_spq_chk (.*);

// ===== tb/sorted_insert_priority_queue_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-insert priority queue checker
// Watches both channels of the queue core. It keeps its own sorted copy of the
// store, works out the result of every accepted request and compares each
// result with the oldest one still owed.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core_checker import spq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   op_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic [PriceW-1:0]      price_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic signed [KeyW-1:0] out_key_i,
  input  logic [PriceW-1:0]      out_price_i,
  input  logic [1:0]             status_i,
  input  logic [FillW-1:0]       fill_i,
  output int unsigned            fail_count_o,
  output int unsigned            results_due_o
);

  typedef struct {
    logic signed [KeyW-1:0] key;
    logic [PriceW-1:0]      price;
    spq_status_e            status;
    logic [FillW-1:0]       fill;
  } queue_result_t;

  logic signed [KeyW-1:0] held_keys [DEPTH];
  logic [PriceW-1:0]      held_prices [DEPTH];
  int                     held_count;
  int unsigned            mismatches;
  queue_result_t          owed_results [$];
  queue_result_t          owed;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] queue mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Applies one request to the shadow store and returns the result it owes.
  function automatic queue_result_t apply_request(input spq_op_e op,
                                                  input logic signed [KeyW-1:0] key,
                                                  input logic [PriceW-1:0] price);
    queue_result_t res;
    int slot;
    int idx;
    res.key = '0;
    res.price = '0;
    res.status = ST_DONE;
    if (op == OP_INSERT) begin
      if (held_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // The new entry goes ahead of every stored entry with an equal key.
        slot = 0;
        while (slot < held_count && held_keys[slot] < key) slot++;
        for (idx = held_count; idx > slot; idx--) begin
          held_keys[idx] = held_keys[idx-1];
          held_prices[idx] = held_prices[idx-1];
        end
        held_keys[slot] = key;
        held_prices[slot] = price;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.key = held_keys[0];
      res.price = held_prices[0];
      for (idx = 1; idx < held_count; idx++) begin
        held_keys[idx-1] = held_keys[idx];
        held_prices[idx-1] = held_prices[idx];
      end
      held_count--;
    end
    res.fill = FillW'(held_count);
    return res;
  endfunction

  // The result taken at an edge is compared before the request accepted at
  // the same edge is predicted, so a stray result can never match it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      owed_results.delete();
      results_due_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result with none owed: key %0d price %h status %0d fill %0d",
                                    out_key_i, out_price_i, status_i, fill_i));
        end else begin
          owed = owed_results.pop_front();
          if (out_key_i !== owed.key)
            report_mismatch($sformatf("out_key %0d, expected %0d", out_key_i, owed.key));
          if (out_price_i !== owed.price)
            report_mismatch($sformatf("out_price %h, expected %h", out_price_i, owed.price));
          if (status_i !== owed.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, owed.status));
          if (fill_i !== owed.fill)
            report_mismatch($sformatf("fill %0d, expected %0d", fill_i, owed.fill));
        end
      end
      if (in_valid_i && in_ready_i)
        owed_results.push_back(apply_request(spq_op_e'(op_i), key_i, price_i));
      results_due_o <= owed_results.size();
    end
  end

  initial begin
    mismatches = 0;
  end

endmodule

// ===== tb/sorted_insert_priority_queue_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-insert priority queue testbench
// Drives corner-case and random insert/pop requests into the queue core with
// random gaps on both channels, lets the checker predict and compare every
// result, and reports the verdict.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core_test;
  import spq_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned PhaseCount = 12;
  localparam logic signed [KeyW-1:0] MinKey = {1'b1, {(KeyW-1){1'b0}}};
  localparam logic signed [KeyW-1:0] MaxKey = {1'b0, {(KeyW-1){1'b1}}};
  localparam logic signed [KeyW-1:0] CornerKeys [16] = '{
    32'sd5, MinKey, MaxKey, 32'sd0, -32'sd1, 32'sd5, 32'sd5, MaxKey - 1,
    MinKey + 1, 32'sd100, -32'sd100, 32'sd1, 32'sd5, 32'sd0, MaxKey, MinKey
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   op_i = OP_INSERT;
  logic signed [KeyW-1:0] key_i = '0;
  logic [PriceW-1:0]      price_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [KeyW-1:0] out_key_o;
  logic [PriceW-1:0]      out_price_o;
  logic [1:0]             status_o;
  logic [FillW-1:0]       fill_o;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned cycles = 0;
  logic        steady = 1'b0;

  sorted_insert_priority_queue_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .price_i     (price_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_key_o   (out_key_o),
    .out_price_o (out_price_o),
    .status_o    (status_o),
    .fill_o      (fill_o)
  );

  sorted_insert_priority_queue_core_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .key_i         (key_i),
    .price_i       (price_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_key_i     (out_key_o),
    .out_price_i   (out_price_o),
    .status_i      (status_o),
    .fill_i        (fill_o),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [KeyW-1:0] pick_key(input int mode);
    logic signed [KeyW-1:0] k;
    case (mode)
      0: k = KeyW'($urandom_range(0, 6)) - 3;  // dense keys, many ties
      1: k = $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0: k = MinKey;
          1: k = MaxKey;
          2: k = '0;
          3: k = '1;
          default: k = $urandom();
        endcase
      end
    endcase
    return k;
  endfunction

  // Holds the request on the channel until it is accepted.
  task automatic send_request(input spq_op_e op, input logic signed [KeyW-1:0] key,
                              input logic [PriceW-1:0] price);
    in_valid_i <= 1'b1;
    op_i <= op;
    key_i <= key;
    price_i <= price;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_sender();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  // Receiver: takes one result per pass after a random stall.
  initial begin
    int stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int phase;
    int item;
    int insert_pct;
    int key_mode;
    spq_op_e op;
    logic [PriceW-1:0] price;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pop on an empty store, fill it with extreme and tied keys, overfill it,
    // then take the smallest entries back out.
    send_request(OP_POP, '0, '0);
    idle_sender();
    for (item = 0; item < 16; item++) begin
      price = (item == 0) ? '0 : (item == 1) ? '1 : $urandom();
      send_request(OP_INSERT, CornerKeys[item], price);
      idle_sender();
    end
    send_request(OP_INSERT, 32'sd3, $urandom());
    idle_sender();
    for (item = 0; item < 6; item++) begin
      send_request(OP_POP, $urandom(), $urandom());
      idle_sender();
    end
    wait_until_drained();

    // Phases lean toward filling or draining so both the full and the empty
    // cases keep coming up.
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 5)
        0: insert_pct = 85;
        1: insert_pct = 15;
        2: insert_pct = 50;
        3: insert_pct = 65;
        default: insert_pct = 35;
      endcase
      key_mode = $urandom_range(0, 2);
      steady = (phase % 4 == 3);
      for (item = 0; item < PhaseItems; item++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
        send_request(op, pick_key(key_mode), $urandom());
        idle_sender();
      end
      if (phase % 3 == 2) wait_until_drained();
    end
    steady = 1'b0;

    wait_until_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_insert_priority_queue_core.sv
hw/rtl/spq_chk.sv
tb/sorted_insert_priority_queue_core_checker.sv
tb/sorted_insert_priority_queue_core_test.sv
